FILE: rtl/core/igc_pkg.sv
// Shared types, constants and saturation helpers for the ideal-gas conversion pipeline.
package igc_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned GM1_W     = 18;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned SPEED_W   = 31;
  localparam int unsigned MAG_W     = 2 * WORD_W;

  // divider and multiplier widths
  localparam int unsigned DIVA_NW = WORD_W + FRAC_W;
  localparam int unsigned EDEN_W  = WORD_W + GM1_W;
  localparam int unsigned DIVB_NW = WORD_W + 2 * FRAC_W;
  localparam int unsigned KIN_W   = 2 * WORD_W - FRAC_W - 1;
  localparam int unsigned DIFF_W  = KIN_W + 2;
  localparam int unsigned DLIM_W  = KIN_W;
  localparam int unsigned PMUL_W  = DLIM_W + GM1_W;
  localparam int unsigned PRES_W  = PMUL_W - FRAC_W;
  localparam int unsigned G2S_W   = GM1_W + 1;
  localparam int unsigned G2M_W   = G2S_W + GM1_W;
  localparam int unsigned G2_W    = G2M_W - FRAC_W;
  localparam int unsigned RAD_W   = G2_W + WORD_W - 1;
  localparam int unsigned ROOT_W  = RAD_W / 2;

  localparam logic [DLIM_W-1:0] DIFF_LIMIT = DLIM_W'(1) << (DLIM_W - 1);

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLAMP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_GM1   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PMASS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HCAP  = 2'd2;

  localparam logic [GM1_W-1:0] GM1_RESET   = 18'd26214;
  localparam logic [CFG_W-1:0] PMASS_RESET = 31'd65536;
  localparam logic [CFG_W-1:0] HCAP_RESET  = 31'd65536;

  localparam logic [MAG_W-1:0] MAG_LIM = (MAG_W'(1) << (WORD_W - 1)) - MAG_W'(1);
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  typedef struct packed {
    logic                     sat;
    logic signed [WORD_W-1:0] val;
  } sword_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] mom;
    logic signed [WORD_W-1:0] etot;
    logic                     last;
  } diva_side_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rho;
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] pres;
    logic signed [WORD_W-1:0] nden;
    logic                     sat;
    logic                     eden_zero;
    logic                     last;
  } divb_side_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rho;
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] pres;
    logic signed [WORD_W-1:0] nden;
    logic signed [WORD_W-1:0] eint;
    logic                     sat;
    logic                     clamped;
    logic                     last;
  } sq_side_t;

  typedef struct packed {
    sq_side_t            base;
    logic [ROOT_W-1:0]   root;
  } divc_side_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] density;
    logic signed [WORD_W-1:0] velocity;
    logic signed [WORD_W-1:0] pressure;
    logic signed [WORD_W-1:0] ndens;
    logic signed [WORD_W-1:0] eint_spec;
    logic [SPEED_W-1:0]       c_sound;
    logic signed [WORD_W-1:0] temperature;
    logic [STATUS_W-1:0]      status;
    logic                     last_out;
  } result_t;

  function automatic logic [WORD_W-1:0] mag_of(input logic signed [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] n;
    n = -v;
    return v[WORD_W-1] ? WORD_W'(n) : WORD_W'(v);
  endfunction

  // Clip a magnitude with sign into the signed word range.
  function automatic sword_t sat_pack(input logic [MAG_W-1:0] mag, input logic neg);
    sword_t r;
    logic [WORD_W-1:0] m;
    m = mag[WORD_W-1:0];
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > MAG_LIM) begin
        r.sat = 1'b1;
        r.val = WORD_MAX;
      end else begin
        r.val = m;
      end
    end else begin
      if (mag > MAG_LIM + MAG_W'(1)) begin
        r.sat = 1'b1;
        r.val = WORD_MIN;
      end else begin
        r.val = -m;
      end
    end
    return r;
  endfunction

  // Quotient for a zero divisor: follow the numerator's sign.
  function automatic sword_t zero_div(input logic signed [WORD_W-1:0] num);
    sword_t r;
    r.sat = (num != '0);
    if (num == '0) begin
      r.val = '0;
    end else begin
      r.val = num[WORD_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/igc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
module igc_div #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]      valid_q;
  logic [NUM_W-1:0]    nq_q   [NUM_W+1];
  logic [DEN_W-1:0]    rem_q  [NUM_W+1];
  logic [DEN_W-1:0]    den_q  [NUM_W+1];
  logic [SIDE_W-1:0]   side_q [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NUM_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]   <= num_i;
      rem_q[0]  <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0]   acc;
    logic [DEN_W:0]   dif;
    logic             ge;
    logic [DEN_W-1:0] rem_d;
    logic [NUM_W-1:0] nq_d;

    always_comb begin
      // shift the next numerator bit into the partial remainder
      acc   = {rem_q[k], nq_q[k][NUM_W-1]};
      dif   = acc - {1'b0, den_q[k]};
      ge    = (acc >= {1'b0, den_q[k]});
      rem_d = ge ? dif[DEN_W-1:0] : acc[DEN_W-1:0];
      nq_d  = {nq_q[k][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k+1]   <= nq_d;
        rem_q[k+1]  <= rem_d;
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = valid_q[NUM_W];
  assign quo_o   = nq_q[NUM_W];
  assign side_o  = side_q[NUM_W];

endmodule

FILE: rtl/core/igc_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband data.
module igc_sqrt #(
  parameter int unsigned RAD_W  = 52,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned ROOT_W = RAD_W / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [ROOT_W:0]     valid_q;
  logic [RAD_W-1:0]    rad_q  [ROOT_W+1];
  logic [ROOT_W:0]     rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_q [ROOT_W+1];
  logic [SIDE_W-1:0]   side_q [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ROOT_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+2:0] acc;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] nrem;
    logic              ge;

    always_comb begin
      // bring down the next radicand bit pair and try root*4+1
      acc   = {rem_q[k], rad_q[k][RAD_W-1:RAD_W-2]};
      trial = {1'b0, root_q[k], 2'b01};
      ge    = (acc >= trial);
      nrem  = ge ? (acc - trial) : acc;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= {rad_q[k][RAD_W-3:0], 2'b00};
        rem_q[k+1]  <= nrem[ROOT_W:0];
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = valid_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign side_o  = side_q[ROOT_W];

endmodule

FILE: rtl/core/ideal_gas_cons_to_prim.sv
// Ideal-gas conserved-to-primitive conversion, built as a chain of bit-per-stage dividers and a root.
// Throughput is one cell per cycle while the output queue is not full. The path runs through
// the input register, the velocity and number density dividers, stages 1 to 5, the energy
// divider, stages 6 and 7, the root, the temperature divider and the output queue; a full
// 2-entry output queue stalls all.
// Reset clears all valid bits and the output queue and loads the register defaults.
module ideal_gas_cons_to_prim (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [igc_pkg::WORD_W-1:0]    mass_density_i,
  input  logic signed [igc_pkg::WORD_W-1:0]    momentum_i,
  input  logic signed [igc_pkg::WORD_W-1:0]    total_energy_i,
  input  logic                                 last_cell_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [igc_pkg::WORD_W-1:0]    density_o,
  output logic signed [igc_pkg::WORD_W-1:0]    velocity_o,
  output logic signed [igc_pkg::WORD_W-1:0]    pressure_o,
  output logic signed [igc_pkg::WORD_W-1:0]    ndens_o,
  output logic signed [igc_pkg::WORD_W-1:0]    eint_spec_o,
  output logic [igc_pkg::SPEED_W-1:0]          c_sound_o,
  output logic signed [igc_pkg::WORD_W-1:0]    temperature_o,
  output logic [igc_pkg::STATUS_W-1:0]         status_o,
  output logic                                 last_out_o,
  input  logic                                 cfg_we_i,
  input  logic [igc_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [igc_pkg::CFG_W-1:0]            cfg_data_i
);
  import igc_pkg::*;

  localparam int unsigned FIFO_DEPTH = 2;

  // configuration
  logic [GM1_W-1:0] gm1_q;
  logic [CFG_W-1:0] pmass_q;
  logic [CFG_W-1:0] hcap_q;
  logic [G2_W-1:0]  g2_q;
  logic [G2M_W-1:0] g2_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gm1_q   <= GM1_RESET;
      pmass_q <= PMASS_RESET;
      hcap_q  <= HCAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GM1:   gm1_q   <= cfg_data_i[GM1_W-1:0];
        REG_PMASS: pmass_q <= cfg_data_i;
        REG_HCAP:  hcap_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // gamma*(gamma-1), registered from the gamma-1 register
  assign g2_full = (G2M_W'(gm1_q) + G2M_W'(1 << FRAC_W)) * G2M_W'(gm1_q);

  always_ff @(posedge clk_i) begin
    g2_q <= g2_full[G2M_W-1:FRAC_W];
  end

  logic en;
  logic [1:0] cnt_q;
  assign en         = (cnt_q != 2'(FIFO_DEPTH));
  assign in_ready_o = en;

  // stage 0: input register
  logic                     s0_valid_q;
  logic signed [WORD_W-1:0] s0_rho_q, s0_mom_q, s0_etot_q;
  logic                     s0_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_rho_q  <= mass_density_i;
      s0_mom_q  <= momentum_i;
      s0_etot_q <= total_energy_i;
      s0_last_q <= last_cell_i;
    end
  end

  // velocity and number density dividers
  diva_side_t               da_side_in, da_side;
  logic [$bits(diva_side_t)-1:0] da_side_raw;
  logic                     da_valid, dn_valid;
  logic [DIVA_NW-1:0]       da_q, dn_q;
  logic [WORD_W-1:0]        dn_side;

  assign da_side_in = '{mom: s0_mom_q, etot: s0_etot_q, last: s0_last_q};

  igc_div #(
    .NUM_W (DIVA_NW),
    .DEN_W (WORD_W),
    .SIDE_W($bits(diva_side_t))
  ) u_div_vel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s0_valid_q),
    .num_i  ({mag_of(s0_mom_q), FRAC_W'(0)}),
    .den_i  (mag_of(s0_rho_q)),
    .side_i (da_side_in),
    .valid_o(da_valid),
    .quo_o  (da_q),
    .side_o (da_side_raw)
  );

  igc_div #(
    .NUM_W (DIVA_NW),
    .DEN_W (CFG_W),
    .SIDE_W(WORD_W)
  ) u_div_nden (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s0_valid_q),
    .num_i  ({mag_of(s0_rho_q), FRAC_W'(0)}),
    .den_i  (pmass_q),
    .side_i (s0_rho_q),
    .valid_o(dn_valid),
    .quo_o  (dn_q),
    .side_o (dn_side)
  );

  assign da_side = diva_side_t'(da_side_raw);

  // stage 1: finish velocity and number density
  logic signed [WORD_W-1:0] s1_rho;
  sword_t                   vel_w, nden_w;

  always_comb begin
    s1_rho = dn_side;
    if (s1_rho == '0) begin
      vel_w = zero_div(da_side.mom);
    end else begin
      vel_w = sat_pack(MAG_W'(da_q), da_side.mom[WORD_W-1] ^ s1_rho[WORD_W-1]);
    end
    if (pmass_q == '0) begin
      nden_w = zero_div(s1_rho);
    end else begin
      nden_w = sat_pack(MAG_W'(dn_q), s1_rho[WORD_W-1]);
    end
  end

  logic                     s1_valid_q, s1_last_q, s1_sat_q;
  logic signed [WORD_W-1:0] s1_rho_q, s1_mom_q, s1_etot_q, s1_vel_q, s1_nden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= da_valid & dn_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rho_q  <= s1_rho;
      s1_mom_q  <= da_side.mom;
      s1_etot_q <= da_side.etot;
      s1_last_q <= da_side.last;
      s1_vel_q  <= vel_w.val;
      s1_nden_q <= nden_w.val;
      s1_sat_q  <= vel_w.sat | nden_w.sat;
    end
  end

  // stage 2: momentum*velocity and density*(gamma-1)
  logic                     s2_valid_q, s2_last_q, s2_sat_q, s2_kneg_q;
  logic signed [WORD_W-1:0] s2_rho_q, s2_etot_q, s2_vel_q, s2_nden_q;
  logic [MAG_W-1:0]         s2_kprod_q;
  logic [EDEN_W-1:0]        s2_eden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_kprod_q <= MAG_W'(mag_of(s1_mom_q)) * MAG_W'(mag_of(s1_vel_q));
      s2_eden_q  <= EDEN_W'(mag_of(s1_rho_q)) * EDEN_W'(gm1_q);
      s2_kneg_q  <= s1_mom_q[WORD_W-1] ^ s1_vel_q[WORD_W-1];
      s2_rho_q   <= s1_rho_q;
      s2_etot_q  <= s1_etot_q;
      s2_vel_q   <= s1_vel_q;
      s2_nden_q  <= s1_nden_q;
      s2_sat_q   <= s1_sat_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // stage 3: energy minus kinetic term
  logic [KIN_W-1:0]         kin;
  logic signed [DIFF_W-1:0] kin_s, diff_w;

  always_comb begin
    kin    = s2_kprod_q[MAG_W-1:FRAC_W+1];
    kin_s  = s2_kneg_q ? -$signed(DIFF_W'(kin)) : $signed(DIFF_W'(kin));
    diff_w = DIFF_W'(s2_etot_q) - kin_s;
  end

  logic                     s3_valid_q, s3_last_q, s3_sat_q;
  logic signed [WORD_W-1:0] s3_rho_q, s3_vel_q, s3_nden_q;
  logic signed [DIFF_W-1:0] s3_diff_q;
  logic [EDEN_W-1:0]        s3_eden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_diff_q <= diff_w;
      s3_eden_q <= s2_eden_q;
      s3_rho_q  <= s2_rho_q;
      s3_vel_q  <= s2_vel_q;
      s3_nden_q <= s2_nden_q;
      s3_sat_q  <= s2_sat_q;
      s3_last_q <= s2_last_q;
    end
  end

  // stage 4: clipped difference times (gamma-1)
  logic signed [DIFF_W-1:0] diff_n;
  logic [DIFF_W-1:0]        dabs;
  logic [DLIM_W-1:0]        dclip;
  logic [PMUL_W-1:0]        pmul;

  always_comb begin
    diff_n = -s3_diff_q;
    dabs   = s3_diff_q[DIFF_W-1] ? DIFF_W'(diff_n) : DIFF_W'(s3_diff_q);
    dclip  = (dabs > DIFF_W'(DIFF_LIMIT)) ? DIFF_LIMIT : dabs[DLIM_W-1:0];
    pmul   = PMUL_W'(dclip) * PMUL_W'(gm1_q);
  end

  logic                     s4_valid_q, s4_last_q, s4_sat_q, s4_pneg_q;
  logic signed [WORD_W-1:0] s4_rho_q, s4_vel_q, s4_nden_q;
  logic [PRES_W-1:0]        s4_pmag_q;
  logic [EDEN_W-1:0]        s4_eden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pmag_q <= pmul[PMUL_W-1:FRAC_W];
      s4_pneg_q <= s3_diff_q[DIFF_W-1];
      s4_eden_q <= s3_eden_q;
      s4_rho_q  <= s3_rho_q;
      s4_vel_q  <= s3_vel_q;
      s4_nden_q <= s3_nden_q;
      s4_sat_q  <= s3_sat_q;
      s4_last_q <= s3_last_q;
    end
  end

  // stage 5: pressure
  sword_t pres_w;
  assign pres_w = sat_pack(MAG_W'(s4_pmag_q), s4_pneg_q);

  logic                     s5_valid_q;
  divb_side_t               s5_side_q;
  logic [EDEN_W-1:0]        s5_eden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_eden_q <= s4_eden_q;
      s5_side_q <= '{rho: s4_rho_q, vel: s4_vel_q, pres: pres_w.val, nden: s4_nden_q,
                     sat: s4_sat_q | pres_w.sat, eden_zero: (s4_eden_q == '0),
                     last: s4_last_q};
    end
  end

  // internal energy divider: |p| << 2F over |rho|*(gamma-1)
  logic                           db_valid;
  logic [DIVB_NW-1:0]             db_q;
  logic [$bits(divb_side_t)-1:0]  db_side_raw;
  divb_side_t                     db_side;

  igc_div #(
    .NUM_W (DIVB_NW),
    .DEN_W (EDEN_W),
    .SIDE_W($bits(divb_side_t))
  ) u_div_eint (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s5_valid_q),
    .num_i  ({mag_of(s5_side_q.pres), (2 * FRAC_W)'(0)}),
    .den_i  (s5_eden_q),
    .side_i (s5_side_q),
    .valid_o(db_valid),
    .quo_o  (db_q),
    .side_o (db_side_raw)
  );

  assign db_side = divb_side_t'(db_side_raw);

  // stage 6: internal energy, clamp for the root
  sword_t eint_w;

  always_comb begin
    if (db_side.eden_zero) begin
      eint_w = zero_div(db_side.pres);
    end else begin
      eint_w = sat_pack(MAG_W'(db_q), db_side.pres[WORD_W-1] ^ db_side.rho[WORD_W-1]);
    end
  end

  logic               s6_valid_q;
  sq_side_t           s6_side_q;
  logic [WORD_W-2:0]  s6_emag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= db_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_emag_q <= eint_w.val[WORD_W-1] ? '0 : eint_w.val[WORD_W-2:0];
      s6_side_q <= '{rho: db_side.rho, vel: db_side.vel, pres: db_side.pres,
                     nden: db_side.nden, eint: eint_w.val,
                     sat: db_side.sat | eint_w.sat, clamped: eint_w.val[WORD_W-1],
                     last: db_side.last};
    end
  end

  // stage 7: radicand gamma*(gamma-1)*e
  logic             s7_valid_q;
  sq_side_t         s7_side_q;
  logic [RAD_W-1:0] s7_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (en) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_rad_q  <= RAD_W'(g2_q) * RAD_W'(s6_emag_q);
      s7_side_q <= s6_side_q;
    end
  end

  // sound speed root
  logic                         sq_valid;
  logic [ROOT_W-1:0]            sq_root;
  logic [$bits(sq_side_t)-1:0]  sq_side_raw;
  divc_side_t                   dc_side_in;

  igc_sqrt #(
    .RAD_W (RAD_W),
    .SIDE_W($bits(sq_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s7_valid_q),
    .rad_i  (s7_rad_q),
    .side_i (s7_side_q),
    .valid_o(sq_valid),
    .root_o (sq_root),
    .side_o (sq_side_raw)
  );

  assign dc_side_in = '{base: sq_side_t'(sq_side_raw), root: sq_root};

  // temperature divider
  logic                           dc_valid;
  logic [DIVA_NW-1:0]             dc_q;
  logic [$bits(divc_side_t)-1:0]  dc_side_raw;
  divc_side_t                     dc_side;

  igc_div #(
    .NUM_W (DIVA_NW),
    .DEN_W (CFG_W),
    .SIDE_W($bits(divc_side_t))
  ) u_div_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(sq_valid),
    .num_i  ({mag_of(dc_side_in.base.eint), FRAC_W'(0)}),
    .den_i  (hcap_q),
    .side_i (dc_side_in),
    .valid_o(dc_valid),
    .quo_o  (dc_q),
    .side_o (dc_side_raw)
  );

  assign dc_side = divc_side_t'(dc_side_raw);

  // final: temperature, status, result assembly
  sword_t  temp_w;
  result_t res;

  always_comb begin
    if (hcap_q == '0) begin
      temp_w = zero_div(dc_side.base.eint);
    end else begin
      temp_w = sat_pack(MAG_W'(dc_q), dc_side.base.eint[WORD_W-1]);
    end
    res.density     = dc_side.base.rho;
    res.velocity    = dc_side.base.vel;
    res.pressure    = dc_side.base.pres;
    res.ndens       = dc_side.base.nden;
    res.eint_spec   = dc_side.base.eint;
    res.c_sound     = SPEED_W'(dc_side.root);
    res.temperature = temp_w.val;
    res.last_out    = dc_side.base.last;
    priority if (dc_side.base.rho[WORD_W-1] || dc_side.base.rho == '0) begin
      res.status = ST_NONPOS;
    end else if (dc_side.base.clamped) begin
      res.status = ST_CLAMP;
    end else if (dc_side.base.sat || temp_w.sat) begin
      res.status = ST_SAT;
    end else begin
      res.status = ST_OK;
    end
  end

  // output queue: two entries so the pipeline keeps moving while a result waits
  result_t fifo_q [FIFO_DEPTH];
  logic    wr_ptr_q, rd_ptr_q;
  logic    push, pop;

  assign push = en && dc_valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign density_o     = fifo_q[rd_ptr_q].density;
  assign velocity_o    = fifo_q[rd_ptr_q].velocity;
  assign pressure_o    = fifo_q[rd_ptr_q].pressure;
  assign ndens_o       = fifo_q[rd_ptr_q].ndens;
  assign eint_spec_o   = fifo_q[rd_ptr_q].eint_spec;
  assign c_sound_o     = fifo_q[rd_ptr_q].c_sound;
  assign temperature_o = fifo_q[rd_ptr_q].temperature;
  assign status_o      = fifo_q[rd_ptr_q].status;
  assign last_out_o    = fifo_q[rd_ptr_q].last_out;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the ideal-gas conserved-to-primitive converter.
`timescale 1ns / 100ps

module tb_top;
  import igc_pkg::*;

  localparam longint WMAX = 64'sh7FFF_FFFF;
  localparam longint WMIN = -64'sh8000_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic signed [WORD_W-1:0] rho;
    logic signed [WORD_W-1:0] mom;
    logic signed [WORD_W-1:0] etot;
    logic                     last;
    logic                     typed;
    result_t                  res;
  } cell_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [WORD_W-1:0] mass_density_i = '0;
  logic signed [WORD_W-1:0] momentum_i = '0;
  logic signed [WORD_W-1:0] total_energy_i = '0;
  logic last_cell_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [WORD_W-1:0] density_o, velocity_o, pressure_o, ndens_o;
  logic signed [WORD_W-1:0] eint_spec_o, temperature_o;
  logic [SPEED_W-1:0] c_sound_o;
  logic [STATUS_W-1:0] status_o;
  logic last_out_o;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = REG_GM1;
  logic [CFG_W-1:0] cfg_data_i = '0;

  bit [63:0] gm1_q, pmass_q, hcap_q;
  result_t prim_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_cnt = 0;

  cell_row_t cell_tab[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 32'sd0, ST_NONPOS, 1'b0}},
    '{32'sd65536, 32'sd0, 32'sd0, 1'b1, 1'b1,
      '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 31'd0, 32'sd0, ST_OK, 1'b1}},
    '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 1'b0, '0},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0, '0},
    '{32'sd1, 32'sh7FFFFFFF, 32'sd0, 1'b0, 1'b0, '0},
    '{-32'sd65536, 32'sd65536, 32'sd65536, 1'b0, 1'b0, '0},
    '{32'sd65536, 32'sd0, -32'sd65536, 1'b0, 1'b0, '0},
    '{32'sd65536, 32'sd131072, 32'sd65536, 1'b0, 1'b0, '0},
    '{32'sd0, -32'sd1, 32'sd5, 1'b1, 1'b0, '0},
    '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b0, 1'b0, '0},
    '{32'sd1, 32'sd0, 32'sh7FFFFFFF, 1'b0, 1'b0, '0},
    '{32'sd131072, -32'sd65536, 32'sd1000000, 1'b0, 1'b0, '0},
    '{32'sh80000000, 32'sd1, 32'sh7FFFFFFF, 1'b1, 1'b0, '0},
    '{32'sd1, 32'sd1, 32'sh80000000, 1'b0, 1'b0, '0}
  };

  bit [63:0] cfg_sets[6][3] = '{
    '{64'd1, 64'd1, 64'd1},
    '{64'd131072, 64'd2147483647, 64'd2147483647},
    '{64'd65536, 64'd1, 64'd2147483647},
    '{64'd0, 64'd0, 64'd0},
    '{64'd98304, 64'd4096, 64'd300000},
    '{64'd26214, 64'd65536, 64'd65536}
  };

  ideal_gas_cons_to_prim dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic bit [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clip_word(input bit [63:0] mag, input bit neg, inout bit sat);
    if (!neg) begin
      if (mag > 64'(WMAX)) begin
        sat = 1'b1;
        return WMAX;
      end
      return longint'(mag);
    end
    if (mag > 64'(WMAX) + 1) begin
      sat = 1'b1;
      return WMIN;
    end
    return -longint'(mag);
  endfunction

  function automatic longint fx_div(input longint num, input longint den, inout bit sat);
    if (den == 0) begin
      if (num == 0) return 0;
      sat = 1'b1;
      return num > 0 ? WMAX : WMIN;
    end
    return clip_word((abs64(num) << FRAC_W) / abs64(den), (num < 0) != (den < 0), sat);
  endfunction

  function automatic bit [63:0] floor_root(input bit [63:0] x);
    bit [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic result_t gas_primitives(input logic signed [WORD_W-1:0] rho_w,
                                             input logic signed [WORD_W-1:0] mom_w,
                                             input logic signed [WORD_W-1:0] etot_w,
                                             input logic last);
    result_t r;
    bit sat, clamped;
    longint rho, mom, etot, vel, kin, diff, pres, nden, eint, temp;
    bit [63:0] dmag, emag, eden, g2;
    sat = 1'b0;
    clamped = 1'b0;
    rho = rho_w;
    mom = mom_w;
    etot = etot_w;
    vel = fx_div(mom, rho, sat);
    kin = longint'((abs64(mom) * abs64(vel)) >> (FRAC_W + 1));
    if ((mom < 0) != (vel < 0)) kin = -kin;
    diff = etot - kin;
    dmag = abs64(diff);
    if (dmag > (64'd1 << 46)) dmag = 64'd1 << 46;
    pres = clip_word((dmag * gm1_q) >> FRAC_W, diff < 0, sat);
    nden = fx_div(rho, longint'(pmass_q), sat);
    eden = abs64(rho) * gm1_q;
    if (eden == 0) begin
      if (pres == 0) begin
        eint = 0;
      end else begin
        sat = 1'b1;
        eint = pres > 0 ? WMAX : WMIN;
      end
    end else begin
      eint = clip_word((abs64(pres) << (2 * FRAC_W)) / eden, (pres < 0) != (rho < 0), sat);
    end
    // negative energy: keep it on the outputs, use zero under the root
    clamped = eint < 0;
    emag = clamped ? 64'd0 : 64'(eint);
    g2 = ((gm1_q + (64'd1 << FRAC_W)) * gm1_q) >> FRAC_W;
    temp = fx_div(eint, longint'(hcap_q), sat);
    r.density = rho_w;
    r.velocity = vel[WORD_W-1:0];
    r.pressure = pres[WORD_W-1:0];
    r.ndens = nden[WORD_W-1:0];
    r.eint_spec = eint[WORD_W-1:0];
    r.c_sound = SPEED_W'(floor_root(g2 * emag));
    r.temperature = temp[WORD_W-1:0];
    if (rho <= 0) r.status = ST_NONPOS;
    else if (clamped) r.status = ST_CLAMP;
    else if (sat) r.status = ST_SAT;
    else r.status = ST_OK;
    r.last_out = last;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_cell(input logic signed [WORD_W-1:0] rho,
                           input logic signed [WORD_W-1:0] mom,
                           input logic signed [WORD_W-1:0] etot,
                           input logic last, input bit typed, input result_t res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mass_density_i <= rho;
    momentum_i <= mom;
    total_energy_i <= etot;
    last_cell_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    prim_q.push_back(typed ? res : gas_primitives(rho, mom, etot, last));
  endtask

  task automatic write_regs(input bit [63:0] gm1, input bit [63:0] pm, input bit [63:0] hc);
    wait (prim_q.size() == 0);
    @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= (i == 0) ? REG_GM1 : (i == 1) ? REG_PMASS : REG_HCAP;
      cfg_data_i <= CFG_W'((i == 0) ? gm1 : (i == 1) ? pm : hc);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    gm1_q = gm1 & 64'h3FFFF;
    pmass_q = pm & 64'h7FFFFFFF;
    hcap_q = hc & 64'h7FFFFFFF;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sd0 : 32'sd1;
      default: return 32'(int'($urandom_range(0, 32'h3FFFFF)) - 32'h1FFFFF);
    endcase
  endfunction

  // checker and output stall generator
  always @(posedge clk_i) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (prim_q.size() == 0) begin
          errors++;
          $display("%0t: transfer with no expected result, actual density %0d",
                   $time, density_o);
        end else begin
          want = prim_q.pop_front();
          check_field("density", want.density, density_o);
          check_field("velocity", want.velocity, velocity_o);
          check_field("pressure", want.pressure, pressure_o);
          check_field("ndens", want.ndens, ndens_o);
          check_field("eint_spec", want.eint_spec, eint_spec_o);
          check_field("c_sound", want.c_sound, c_sound_o);
          check_field("temperature", want.temperature, temperature_o);
          check_field("status", want.status, status_o);
          check_field("last_out", want.last_out, last_out_o);
        end
        stall_cnt = quiet ? 0 : $urandom_range(0, 3);
        out_ready_i <= (stall_cnt == 0);
      end else if (stall_cnt != 0) begin
        stall_cnt = stall_cnt - 1;
        out_ready_i <= (stall_cnt == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int kind;
    logic signed [WORD_W-1:0] rho, mom, etot;
    gm1_q = 64'(GM1_RESET);
    pmass_q = 64'(PMASS_RESET);
    hcap_q = 64'(HCAP_RESET);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (cell_tab[i])
      send_cell(cell_tab[i].rho, cell_tab[i].mom, cell_tab[i].etot, cell_tab[i].last,
                cell_tab[i].typed, cell_tab[i].res);
    for (int p = 0; p < 6; p++) begin
      in_valid_i <= 1'b0;
      write_regs(cfg_sets[p][0], cfg_sets[p][1], cfg_sets[p][2]);
      quiet = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // plausible gas cell: positive density, non-negative energy
          rho = $urandom_range(32'h1000, 32'h00400000);
          mom = 32'(int'($urandom_range(0, 32'h7FFFFF)) - 32'h3FFFFF);
          etot = $urandom_range(0, 32'h0FFFFFFF);
        end else begin
          rho = pick_word($urandom_range(0, 3));
          mom = pick_word($urandom_range(0, 3));
          etot = pick_word($urandom_range(0, 3));
        end
        send_cell(rho, mom, etot, 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    wait (prim_q.size() == 0);
    repeat (250) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
